FILE: hdl/bounded_array_list_engine_macros.svh
// ----------------------------------------------------------------------------
// bounded array list engine assertion macros
// shared concurrent assertion forms for the list engine modules
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ARRAY_LIST_ENGINE_MACROS_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_MACROS_SVH

// same-cycle implication
`define BLE_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BLE_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/ble_pkg.sv
// ----------------------------------------------------------------------------
// ble_pkg
// shared types and constants of the bounded array list engine
// ----------------------------------------------------------------------------
package ble_pkg;

   localparam int CAPACITY_DEF   = 8;
   localparam int VALUE_BITS_DEF = 8;
   localparam int QUEUE_DEPTH    = 2;

   localparam int CMD_WIDTH   = 2;
   localparam int POS_WIDTH   = 3;
   localparam int VAL_WIDTH   = 8;
   localparam int COUNT_WIDTH = 4;

   localparam logic [CMD_WIDTH-1:0] CMD_INS_BEFORE = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_INS_AFTER  = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_INS_SORTED = 2'd2;
   localparam logic [CMD_WIDTH-1:0] CMD_DELETE     = 2'd3;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_BADPOS = 2'd1,
      ST_FULL   = 2'd2,
      ST_EMPTY  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      JOB_LIST = 2'd0,
      JOB_INS  = 2'd1,
      JOB_SORT = 2'd2,
      JOB_DEL  = 2'd3
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      status_type   status;
   } job_ctl_type;

endpackage

FILE: hdl/ble_queue.sv
// ----------------------------------------------------------------------------
// ble_queue
// short first-in first-out job queue between the front and back parts
// ----------------------------------------------------------------------------
`include "bounded_array_list_engine_macros.svh"

module ble_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             full,
   output logic             empty
);

   localparam int DEPTH = ble_pkg::QUEUE_DEPTH;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW    = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    fill_ff, fill_in;

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
      logic [AW-1:0] r;
      if (p == AW'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + AW'(1);
      end
      return r;
   endfunction

   assign full      = (fill_ff == NW'(DEPTH));
   assign empty     = (fill_ff == '0);
   assign head_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wrap_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? wrap_inc(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + NW'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `BLE_ASSERT_IMPL(a_no_push_full, clock, reset, push, !full || pop, "push into full queue")
   `BLE_ASSERT_IMPL(a_no_pop_empty, clock, reset, pop, !empty, "pop from empty queue")

endmodule

FILE: hdl/ble_front.sv
// ----------------------------------------------------------------------------
// ble_front
// takes commands, checks them against the tracked count and builds jobs
// ----------------------------------------------------------------------------
module ble_front #(
   parameter int CAPACITY   = ble_pkg::CAPACITY_DEF,
   parameter int VALUE_BITS = ble_pkg::VALUE_BITS_DEF,
   localparam int IW        = $clog2(CAPACITY),
   localparam int CW        = $clog2(CAPACITY + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [ble_pkg::CMD_WIDTH-1:0]  req_cmd,
   input  logic [ble_pkg::POS_WIDTH-1:0]  req_position,
   input  logic [ble_pkg::VAL_WIDTH-1:0]  req_value,
   output ble_pkg::job_ctl_type           job_ctl,
   output logic [IW-1:0]                  job_pos,
   output logic [VALUE_BITS-1:0]          job_value,
   output logic [CW-1:0]                  job_cnt_old,
   output logic [CW-1:0]                  job_cnt_new
);

   localparam int CMPW = (CW > ble_pkg::POS_WIDTH) ? CW : ble_pkg::POS_WIDTH;

   logic [CW-1:0]   count_ff, count_in;
   logic [CMPW-1:0] pos_x, cnt_x;
   logic [CMPW:0]   tpos;
   logic            list_full, list_empty, pos_ok;

   assign pos_x      = CMPW'(req_position);
   assign cnt_x      = CMPW'(count_ff);
   assign list_full  = (count_ff >= CW'(CAPACITY));
   assign list_empty = (count_ff == '0);

   always_comb begin
      job_ctl.kind   = ble_pkg::JOB_LIST;
      job_ctl.status = ble_pkg::ST_OK;
      tpos           = (CMPW + 1)'(pos_x);
      pos_ok         = 1'b0;
      case (req_cmd)
         ble_pkg::CMD_INS_BEFORE: begin
            if (pos_x > cnt_x) begin
               job_ctl.status = ble_pkg::ST_BADPOS;
            end else if (list_full) begin
               job_ctl.status = ble_pkg::ST_FULL;
            end else begin
               job_ctl.kind = ble_pkg::JOB_INS;
            end
         end
         ble_pkg::CMD_INS_AFTER: begin
            pos_ok = list_empty ? (pos_x == '0) : (pos_x < cnt_x);
            tpos   = list_empty ? '0 : (CMPW + 1)'(pos_x) + (CMPW + 1)'(1);
            if (!pos_ok) begin
               job_ctl.status = ble_pkg::ST_BADPOS;
            end else if (list_full) begin
               job_ctl.status = ble_pkg::ST_FULL;
            end else begin
               job_ctl.kind = ble_pkg::JOB_INS;
            end
         end
         ble_pkg::CMD_INS_SORTED: begin
            if (list_full) begin
               job_ctl.status = ble_pkg::ST_FULL;
            end else begin
               job_ctl.kind = ble_pkg::JOB_SORT;
            end
         end
         ble_pkg::CMD_DELETE: begin
            if (list_empty) begin
               job_ctl.status = ble_pkg::ST_EMPTY;
            end else if (pos_x >= cnt_x) begin
               job_ctl.status = ble_pkg::ST_BADPOS;
            end else begin
               job_ctl.kind = ble_pkg::JOB_DEL;
            end
         end
         default: begin
            job_ctl.kind = ble_pkg::JOB_LIST;
         end
      endcase
   end

   always_comb begin
      case (job_ctl.kind)
         ble_pkg::JOB_INS, ble_pkg::JOB_SORT: job_cnt_new = count_ff + CW'(1);
         ble_pkg::JOB_DEL:                    job_cnt_new = count_ff - CW'(1);
         default:                             job_cnt_new = count_ff;
      endcase
   end

   assign job_pos     = IW'(tpos);
   assign job_value   = VALUE_BITS'(req_value);
   assign job_cnt_old = count_ff;
   assign count_in    = accept ? job_cnt_new : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

FILE: hdl/ble_back.sv
// ----------------------------------------------------------------------------
// ble_back
// carries out jobs on the entry memory and lists the contents word by word
// ----------------------------------------------------------------------------
`include "bounded_array_list_engine_macros.svh"

module ble_back #(
   parameter int CAPACITY   = ble_pkg::CAPACITY_DEF,
   parameter int VALUE_BITS = ble_pkg::VALUE_BITS_DEF,
   localparam int IW        = $clog2(CAPACITY),
   localparam int CW        = $clog2(CAPACITY + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_empty,
   output logic                             q_pop,
   input  ble_pkg::job_ctl_type             job_ctl,
   input  logic [IW-1:0]                    job_pos,
   input  logic [VALUE_BITS-1:0]            job_value,
   input  logic [CW-1:0]                    job_cnt_old,
   input  logic [CW-1:0]                    job_cnt_new,
   output logic                             rsp_valid,
   output logic [1:0]                       rsp_status,
   output logic [ble_pkg::COUNT_WIDTH-1:0]  rsp_entry_count,
   output logic                             rsp_has_entry,
   output logic [ble_pkg::POS_WIDTH-1:0]    rsp_entry_position,
   output logic [ble_pkg::VAL_WIDTH-1:0]    rsp_entry_value,
   output logic                             rsp_last
);

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_SRCH_RD  = 9'b000000010,
      S_SRCH_CMP = 9'b000000100,
      S_UP_RD    = 9'b000001000,
      S_UP_WR    = 9'b000010000,
      S_PUT      = 9'b000100000,
      S_DN_RD    = 9'b001000000,
      S_DN_WR    = 9'b010000000,
      S_LIST     = 9'b100000000
   } state_type;

   state_type               state_ff, state_in;
   logic [IW-1:0]           idx_ff, idx_in;
   logic [IW-1:0]           pos_ff, pos_in;
   logic [VALUE_BITS-1:0]   val_ff, val_in;
   logic [CW-1:0]           cnt_old_ff, cnt_old_in;
   logic [CW-1:0]           cnt_new_ff, cnt_new_in;
   ble_pkg::status_type     status_ff, status_in;

   logic                    emit_ff, emit_in;
   logic                    has_ff, has_in;
   logic                    last_ff, last_in;
   logic [IW-1:0]           epos_ff, epos_in;
   logic [CW-1:0]           ecount_ff, ecount_in;
   ble_pkg::status_type     estatus_ff, estatus_in;

   logic [VALUE_BITS-1:0]   mem [CAPACITY];
   logic [VALUE_BITS-1:0]   rdata_ff;
   logic [IW-1:0]           rd_addr, wr_addr;
   logic [VALUE_BITS-1:0]   wr_data;
   logic                    wr_en;

   assign rd_addr = (state_ff == S_DN_RD) ? idx_ff + IW'(1) : idx_ff;

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      pos_in     = pos_ff;
      val_in     = val_ff;
      cnt_old_in = cnt_old_ff;
      cnt_new_in = cnt_new_ff;
      status_in  = status_ff;
      emit_in    = 1'b0;
      has_in     = has_ff;
      last_in    = last_ff;
      epos_in    = epos_ff;
      ecount_in  = ecount_ff;
      estatus_in = estatus_ff;
      q_pop      = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = idx_ff;
      wr_data    = rdata_ff;
      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop      = 1'b1;
               pos_in     = job_pos;
               val_in     = job_value;
               cnt_old_in = job_cnt_old;
               cnt_new_in = job_cnt_new;
               status_in  = job_ctl.status;
               idx_in     = '0;
               case (job_ctl.kind)
                  ble_pkg::JOB_INS: begin
                     if (job_cnt_old > CW'(job_pos)) begin
                        idx_in   = IW'(job_cnt_old - CW'(1));
                        state_in = S_UP_RD;
                     end else begin
                        state_in = S_PUT;
                     end
                  end
                  ble_pkg::JOB_SORT: begin
                     if (job_cnt_old == '0) begin
                        pos_in   = '0;
                        state_in = S_PUT;
                     end else begin
                        state_in = S_SRCH_RD;
                     end
                  end
                  ble_pkg::JOB_DEL: begin
                     if (CW'(job_pos) + CW'(1) < job_cnt_old) begin
                        idx_in   = job_pos;
                        state_in = S_DN_RD;
                     end else begin
                        state_in = S_LIST;
                     end
                  end
                  default: begin
                     state_in = S_LIST;
                  end
               endcase
            end
         end
         S_SRCH_RD: begin
            state_in = S_SRCH_CMP;
         end
         S_SRCH_CMP: begin
            if (rdata_ff > val_ff) begin
               pos_in   = idx_ff;
               idx_in   = IW'(cnt_old_ff - CW'(1));
               state_in = S_UP_RD;
            end else if (CW'(idx_ff) + CW'(1) == cnt_old_ff) begin
               pos_in   = IW'(cnt_old_ff);
               state_in = S_PUT;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = S_SRCH_RD;
            end
         end
         S_UP_RD: begin
            state_in = S_UP_WR;
         end
         S_UP_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff + IW'(1);
            if (idx_ff == pos_ff) begin
               state_in = S_PUT;
            end else begin
               idx_in   = idx_ff - IW'(1);
               state_in = S_UP_RD;
            end
         end
         S_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff;
            wr_data  = val_ff;
            idx_in   = '0;
            state_in = S_LIST;
         end
         S_DN_RD: begin
            state_in = S_DN_WR;
         end
         S_DN_WR: begin
            wr_en = 1'b1;
            if (CW'(idx_ff) + CW'(2) == cnt_old_ff) begin
               idx_in   = '0;
               state_in = S_LIST;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = S_DN_RD;
            end
         end
         S_LIST: begin
            emit_in    = 1'b1;
            ecount_in  = cnt_new_ff;
            estatus_in = status_ff;
            if (cnt_new_ff == '0) begin
               has_in   = 1'b0;
               epos_in  = '0;
               last_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               has_in  = 1'b1;
               epos_in = idx_ff;
               last_in = (CW'(idx_ff) + CW'(1) == cnt_new_ff);
               if (CW'(idx_ff) + CW'(1) == cnt_new_ff) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff + IW'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         emit_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         emit_ff  <= emit_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      pos_ff     <= pos_in;
      val_ff     <= val_in;
      cnt_old_ff <= cnt_old_in;
      cnt_new_ff <= cnt_new_in;
      status_ff  <= status_in;
      has_ff     <= has_in;
      last_ff    <= last_in;
      epos_ff    <= epos_in;
      ecount_ff  <= ecount_in;
      estatus_ff <= estatus_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   assign rsp_valid          = emit_ff;
   assign rsp_status         = estatus_ff;
   assign rsp_entry_count    = ble_pkg::COUNT_WIDTH'(ecount_ff);
   assign rsp_has_entry      = has_ff;
   assign rsp_entry_position = ble_pkg::POS_WIDTH'(epos_ff);
   assign rsp_entry_value    = has_ff ? ble_pkg::VAL_WIDTH'(rdata_ff) : '0;
   assign rsp_last           = last_ff;

   `BLE_ASSERT_IMPL(a_empty_word_last, clock, reset, emit_ff && !has_ff, last_ff && (ecount_ff == '0), "empty listing word malformed")
   `BLE_ASSERT_IMPL(a_entry_in_list, clock, reset, emit_ff && has_ff, CW'(epos_ff) < ecount_ff, "listed position beyond count")
   `BLE_ASSERT_IMPL(a_write_in_list, clock, reset, wr_en, CW'(wr_addr) < cnt_new_ff, "memory write beyond new count")
   `BLE_ASSERT_IMPL(a_listing_goes_on, clock, reset, emit_ff && !last_ff, state_ff == S_LIST, "listing stopped before last word")

endmodule

FILE: hdl/bounded_array_list_engine.sv
// ----------------------------------------------------------------------------
// bounded_array_list_engine
// bounded ordered list with positional and sorted insert and delete
// ----------------------------------------------------------------------------
// Commands enter on req_cmd, req_position and req_value; one is taken at a
// rising edge where start is high and busy is low. busy rises while two
// commands wait in the job queue between the checking front and the memory
// back end, and during reset.
// After each command the contents are listed on the rsp_ ports, one word per
// cycle marked by rsp_valid, positions in order, rsp_last on the final word;
// an empty list gives one word with rsp_has_entry low. The receiver cannot
// stall: every word is taken in the cycle it is shown.
// Before the first word, a command passes the job queue and the back end:
// each entry shifted takes a read then a write, each entry examined by a
// sorted insert a read then a compare, and an inserted value a store. The
// registered read of the entry memory is why every shift step is a read
// then a write.
// Synchronous reset empties the list and the job queue; the entry memory is
// not cleared, since only written entries are ever read.
// ----------------------------------------------------------------------------
module bounded_array_list_engine #(
   parameter int CAPACITY   = ble_pkg::CAPACITY_DEF,
   parameter int VALUE_BITS = ble_pkg::VALUE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [ble_pkg::CMD_WIDTH-1:0]    req_cmd,
   input  logic [ble_pkg::POS_WIDTH-1:0]    req_position,
   input  logic [ble_pkg::VAL_WIDTH-1:0]    req_value,
   output logic                             rsp_valid,
   output logic [1:0]                       rsp_status,
   output logic [ble_pkg::COUNT_WIDTH-1:0]  rsp_entry_count,
   output logic                             rsp_has_entry,
   output logic [ble_pkg::POS_WIDTH-1:0]    rsp_entry_position,
   output logic [ble_pkg::VAL_WIDTH-1:0]    rsp_entry_value,
   output logic                             rsp_last
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int JW = $bits(ble_pkg::job_ctl_type) + IW + VALUE_BITS + 2 * CW;

   logic                  accept;
   logic                  q_full, q_empty, q_pop;
   logic [JW-1:0]         q_in, q_head;

   ble_pkg::job_ctl_type  f_ctl, h_ctl;
   logic [IW-1:0]         f_pos, h_pos;
   logic [VALUE_BITS-1:0] f_val, h_val;
   logic [CW-1:0]         f_cnt_old, h_cnt_old;
   logic [CW-1:0]         f_cnt_new, h_cnt_new;

   assign busy   = q_full || reset;
   assign accept = start && !busy;
   assign q_in   = {f_ctl, f_pos, f_val, f_cnt_old, f_cnt_new};
   assign {h_ctl, h_pos, h_val, h_cnt_old, h_cnt_new} = q_head;

   ble_front #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req_cmd      (req_cmd),
      .req_position (req_position),
      .req_value    (req_value),
      .job_ctl      (f_ctl),
      .job_pos      (f_pos),
      .job_value    (f_val),
      .job_cnt_old  (f_cnt_old),
      .job_cnt_new  (f_cnt_new)
   );

   ble_queue #(
      .WIDTH (JW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (q_in),
      .pop       (q_pop),
      .head_data (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   ble_back #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_empty            (q_empty),
      .q_pop              (q_pop),
      .job_ctl            (h_ctl),
      .job_pos            (h_pos),
      .job_value          (h_val),
      .job_cnt_old        (h_cnt_old),
      .job_cnt_new        (h_cnt_new),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_has_entry      (rsp_has_entry),
      .rsp_entry_position (rsp_entry_position),
      .rsp_entry_value    (rsp_entry_value),
      .rsp_last           (rsp_last)
   );

endmodule
